/* hw/rtl/nsht_pkg.sv */
`timescale 1ns / 1ps

package nsht_pkg;

  localparam int FIELD_W = 16;
  localparam int IDX_W = 8;

  localparam int MAX_SEGMENTS_DEFAULT = 256;
  localparam int COORD_BITS_DEFAULT = 16;

  // Largest distance that the result can carry.
  localparam logic [FIELD_W-1:0] DIST_SAT = '1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] query_x;
    logic signed [FIELD_W-1:0] query_y;
    logic [FIELD_W-1:0]        search_radius;
    logic signed [FIELD_W-1:0] seg_start_x;
    logic signed [FIELD_W-1:0] seg_start_y;
    logic signed [FIELD_W-1:0] seg_end_x;
    logic signed [FIELD_W-1:0] seg_end_y;
    logic                      eligible;
    logic                      last_segment;
  } seg_item_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   best_index;
    logic [FIELD_W-1:0] best_distance;
    logic               overflow;
  } hit_result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_PICK,
    S_CASE,
    S_SQR,
    S_DIV,
    S_ROOT,
    S_DONE
  } nsht_state_t;

endpackage

/* hw/rtl/nearest_segment_hit_test.sv */
`timescale 1ns / 1ps

// Nearest segment search over a run of items, one result on the item marked
// last: found, the position of the nearest eligible segment whose distance to
// the query point lies strictly below the radius of the first item, that
// distance (saturated at 65535, or the radius when nothing was found) and an
// overflow flag for runs longer than MAX_SEGMENTS. Items are taken one at a
// time. An item whose nearest point lies inside the segment passes through
// the product lanes, squarer, divider and square root, one that projects
// onto an end point through the product lanes and square root only, and an
// ineligible or overflowed item through none of them. With 16-bit
// coordinates the bit-serial units are ten parallel 17-step product lanes,
// a 35-step squarer, a 35-step divider and an 18-step square root.
// A finished result waits in its own register, so the next item is accepted
// while it is still stalled.
module nearest_segment_hit_test #(
  parameter int MAX_SEGMENTS = nsht_pkg::MAX_SEGMENTS_DEFAULT,
  parameter int COORD_BITS   = nsht_pkg::COORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  seg_valid,
  output logic                  seg_stall,
  input  nsht_pkg::seg_item_t   seg,
  output logic                  res_valid,
  input  logic                  res_stall,
  output nsht_pkg::hit_result_t res
);

  import nsht_pkg::*;

  // Coordinate width after sign extension; beyond the field width the raw
  // bits are taken as a positive value.
  localparam int CV_W  = (COORD_BITS > FIELD_W) ? FIELD_W + 1 : COORD_BITS;
  localparam int D_W   = CV_W + 1;
  localparam int P_W   = 2 * D_W;
  localparam int S_W   = P_W + 1;
  localparam int R_W   = (S_W + 1) / 2;
  localparam int RX_W  = (R_W > FIELD_W) ? R_W : FIELD_W;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  localparam int C_QX = 0;
  localparam int C_QY = 1;
  localparam int C_AX = 2;
  localparam int C_AY = 3;
  localparam int C_BX = 4;
  localparam int C_BY = 5;
  localparam int NUM_COORDS = 6;

  localparam int L_DXX  = 0;
  localparam int L_DYY  = 1;
  localparam int L_PXDX = 2;
  localparam int L_PYDY = 3;
  localparam int L_PXX  = 4;
  localparam int L_PYY  = 5;
  localparam int L_PXDY = 6;
  localparam int L_PYDX = 7;
  localparam int L_EXX  = 8;
  localparam int L_EYY  = 9;
  localparam int NUM_LANES = 10;

  function automatic logic [D_W-1:0] mag(input logic signed [D_W-1:0] v);
    logic [D_W-1:0] u;
    u = v;
    mag = v[D_W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic signed [S_W:0] term(input logic [P_W-1:0] p, input logic neg);
    logic signed [S_W:0] e;
    e = $signed({2'b00, p});
    term = neg ? -e : e;
  endfunction

  nsht_state_t state, state_next;

  seg_item_t cur;
  logic      eval;
  logic [IDX_W-1:0] cur_idx;

  logic             in_run;
  logic [CNT_W-1:0] seg_count;
  logic [FIELD_W-1:0] min_dist;
  logic [IDX_W-1:0]   best_idx;
  logic               hit;
  logic               ovf;

  logic             accept;
  logic [CNT_W-1:0] count_eff;
  logic             full;
  logic             eval_in;

  logic [FIELD_W-1:0]       raw [NUM_COORDS];
  logic signed [CV_W-1:0]   crd [NUM_COORDS];
  logic signed [D_W-1:0]    dx, dy, px, py, ex, ey;

  logic [D_W-1:0]       lane_a [NUM_LANES];
  logic [D_W-1:0]       lane_b [NUM_LANES];
  logic [P_W-1:0]       prod [NUM_LANES];
  logic [NUM_LANES-1:0] lane_busy;

  logic [S_W-1:0]      len_r;
  logic signed [S_W:0] dot_r;
  logic signed [S_W:0] cross_r;
  logic [S_W-1:0]      nstart_r;
  logic [S_W-1:0]      nend_r;
  logic [S_W:0]        cross_u;
  logic                near_start;
  logic                interior;

  logic [2*S_W-1:0] sqr_prod;
  logic             sqr_busy;
  logic [S_W-1:0]   quo;
  logic             div_busy;
  logic [S_W-1:0]   root_n;
  logic [R_W-1:0]   root;
  logic             root_busy;
  logic [RX_W-1:0]  root_x;
  logic [FIELD_W-1:0] seg_dist;

  logic lane_start, sqr_start, div_start, root_start, finish, can_finish;
  logic upd;

  // Input side.
  assign accept    = seg_valid && !seg_stall;
  assign count_eff = in_run ? seg_count : '0;
  assign full      = (count_eff >= CNT_W'(MAX_SEGMENTS));
  assign eval_in   = seg.eligible && !full;

  always_ff @(posedge clk) begin
    if (accept) begin
      cur     <= seg;
      eval    <= eval_in;
      cur_idx <= IDX_W'(count_eff);
    end
  end

  // Coordinates.
  assign raw[C_QX] = cur.query_x;
  assign raw[C_QY] = cur.query_y;
  assign raw[C_AX] = cur.seg_start_x;
  assign raw[C_AY] = cur.seg_start_y;
  assign raw[C_BX] = cur.seg_end_x;
  assign raw[C_BY] = cur.seg_end_y;

  for (genvar i = 0; i < NUM_COORDS; i++) begin : g_coord
    if (COORD_BITS > FIELD_W) begin : g_wide
      assign crd[i] = $signed(CV_W'(raw[i]));
    end else begin : g_narrow
      assign crd[i] = $signed(raw[i][CV_W-1:0]);
    end
  end

  assign dx = crd[C_BX] - crd[C_AX];
  assign dy = crd[C_BY] - crd[C_AY];
  assign px = crd[C_QX] - crd[C_AX];
  assign py = crd[C_QY] - crd[C_AY];
  assign ex = crd[C_QX] - crd[C_BX];
  assign ey = crd[C_QY] - crd[C_BY];

  // Product lanes, all magnitudes; signs are applied when they are combined.
  assign lane_a[L_DXX]  = mag(dx);
  assign lane_b[L_DXX]  = mag(dx);
  assign lane_a[L_DYY]  = mag(dy);
  assign lane_b[L_DYY]  = mag(dy);
  assign lane_a[L_PXDX] = mag(px);
  assign lane_b[L_PXDX] = mag(dx);
  assign lane_a[L_PYDY] = mag(py);
  assign lane_b[L_PYDY] = mag(dy);
  assign lane_a[L_PXX]  = mag(px);
  assign lane_b[L_PXX]  = mag(px);
  assign lane_a[L_PYY]  = mag(py);
  assign lane_b[L_PYY]  = mag(py);
  assign lane_a[L_PXDY] = mag(px);
  assign lane_b[L_PXDY] = mag(dy);
  assign lane_a[L_PYDX] = mag(py);
  assign lane_b[L_PYDX] = mag(dx);
  assign lane_a[L_EXX]  = mag(ex);
  assign lane_b[L_EXX]  = mag(ex);
  assign lane_a[L_EYY]  = mag(ey);
  assign lane_b[L_EYY]  = mag(ey);

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    nsht_mul #(.W(D_W)) u_mul (
      .clk   (clk),
      .rst   (rst),
      .start (lane_start),
      .a     (lane_a[l]),
      .b     (lane_b[l]),
      .busy  (lane_busy[l]),
      .prod  (prod[l])
    );
  end

  always_ff @(posedge clk) begin
    if (state == S_PICK) begin
      len_r    <= S_W'(prod[L_DXX]) + S_W'(prod[L_DYY]);
      dot_r    <= term(prod[L_PXDX], px[D_W-1] ^ dx[D_W-1])
                + term(prod[L_PYDY], py[D_W-1] ^ dy[D_W-1]);
      cross_r  <= term(prod[L_PXDY], px[D_W-1] ^ dy[D_W-1])
                - term(prod[L_PYDX], py[D_W-1] ^ dx[D_W-1]);
      nstart_r <= S_W'(prod[L_PXX]) + S_W'(prod[L_PYY]);
      nend_r   <= S_W'(prod[L_EXX]) + S_W'(prod[L_EYY]);
    end
  end

  // A zero-length segment has a zero dot product, so it falls to the start
  // point together with projections that land before the start.
  assign near_start = dot_r[S_W] || (dot_r == '0);
  assign interior   = !near_start && (dot_r[S_W-1:0] < len_r);
  assign cross_u    = cross_r[S_W] ? (~cross_r + 1'b1) : cross_r;

  // Interior distance is floor(sqrt(cross^2 / len)).
  nsht_mul #(.W(S_W)) u_sqr (
    .clk   (clk),
    .rst   (rst),
    .start (sqr_start),
    .a     (cross_u[S_W-1:0]),
    .b     (cross_u[S_W-1:0]),
    .busy  (sqr_busy),
    .prod  (sqr_prod)
  );

  nsht_div #(.QW(S_W), .DW(S_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sqr_prod),
    .den   (len_r),
    .busy  (div_busy),
    .quo   (quo)
  );

  assign root_n = (state == S_DIV) ? quo : (near_start ? nstart_r : nend_r);

  nsht_sqrt #(.NW(S_W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .n     (root_n),
    .busy  (root_busy),
    .root  (root)
  );

  assign root_x   = RX_W'(root);
  assign seg_dist = (root_x > RX_W'(DIST_SAT)) ? DIST_SAT : root_x[FIELD_W-1:0];

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = eval_in ? S_PREP : S_DONE;
        end
      end
      S_PREP: state_next = S_MUL;
      S_MUL: begin
        if (lane_busy == '0) begin
          state_next = S_PICK;
        end
      end
      S_PICK: state_next = S_CASE;
      S_CASE: state_next = interior ? S_SQR : S_ROOT;
      S_SQR: begin
        if (!sqr_busy) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (!root_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (can_finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign can_finish = !cur.last_segment || !res_valid || !res_stall;

  always_comb begin
    lane_start = 1'b0;
    sqr_start  = 1'b0;
    div_start  = 1'b0;
    root_start = 1'b0;
    finish     = 1'b0;
    seg_stall  = 1'b1;
    unique case (state)
      S_IDLE: seg_stall = 1'b0;
      S_PREP: lane_start = 1'b1;
      S_MUL, S_PICK, S_ROOT: begin
      end
      S_CASE: begin
        sqr_start  = interior;
        root_start = !interior;
      end
      S_SQR: div_start = !sqr_busy;
      S_DIV: root_start = !div_busy;
      S_DONE: finish = can_finish;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Run bookkeeping.
  assign upd = eval && (seg_dist < min_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run    <= 1'b0;
      seg_count <= '0;
      min_dist  <= '0;
      best_idx  <= '0;
      hit       <= 1'b0;
      ovf       <= 1'b0;
    end else if (accept) begin
      in_run    <= 1'b1;
      ovf       <= (in_run && ovf) || full;
      seg_count <= full ? count_eff : CNT_W'(count_eff + 1'b1);
      if (!in_run) begin
        min_dist <= seg.search_radius;
        best_idx <= '0;
        hit      <= 1'b0;
      end
    end else if (finish) begin
      if (upd) begin
        min_dist <= seg_dist;
        best_idx <= cur_idx;
        hit      <= 1'b1;
      end
      if (cur.last_segment) begin
        in_run <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish && cur.last_segment) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && cur.last_segment) begin
      res.found         <= hit || upd;
      res.best_index    <= upd ? cur_idx : best_idx;
      res.best_distance <= upd ? seg_dist : min_dist;
      res.overflow      <= ovf;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_stall |=> state != S_IDLE)
    else $error("accepted item did not start the sequencer");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE && $past(cur.last_segment))
    else $error("result raised outside the end of a last item");

  a_units_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> lane_busy == '0 && !sqr_busy && !div_busy && !root_busy)
    else $error("arithmetic unit still running when the item completes");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    finish && cur.last_segment |=> res_valid)
    else $error("last item completed without a result");

endmodule

/* hw/rtl/nsht_mul.sv */
`timescale 1ns / 1ps

module nsht_mul #(
  parameter int W = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           busy,
  output logic [2*W-1:0] prod
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     mcand;
  logic [2*W-1:0]   acc;
  logic [CNT_W-1:0] steps;
  logic [W:0]       partial;

  // The multiplier bits sit in the low half of the accumulator and leave it
  // one per cycle while the partial sum shifts in from the top.
  assign partial = {1'b0, acc[2*W-1:W]} + (acc[0] ? {1'b0, mcand} : {(W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= CNT_W'(W);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      acc   <= {{W{1'b0}}, b};
    end else if (steps != '0) begin
      acc <= {partial, acc[W-1:1]};
    end
  end

  assign busy = (steps != '0);
  assign prod = acc;

endmodule

/* hw/rtl/nsht_div.sv */
`timescale 1ns / 1ps

module nsht_div #(
  parameter int QW = 35,
  parameter int DW = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QW+DW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic             busy,
  output logic [QW-1:0]    quo
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    divisor;
  logic [QW-1:0]    qsh;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;
  logic [CNT_W-1:0] steps;

  // The quotient is known to fit in QW bits, so the top DW bits of the
  // numerator already lie below the divisor and form the first remainder.
  assign trial = {rem, qsh[QW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = !diff[DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= CNT_W'(QW);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num[QW+DW-1:QW];
      qsh     <= num[QW-1:0];
      divisor <= den;
    end else if (steps != '0) begin
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      qsh <= {qsh[QW-2:0], fits};
    end
  end

  assign busy = (steps != '0);
  assign quo  = qsh;

endmodule

/* hw/rtl/nsht_sqrt.sv */
`timescale 1ns / 1ps

module nsht_sqrt #(
  parameter int NW = 35
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NW-1:0]         n,
  output logic                  busy,
  output logic [(NW+1)/2-1:0]   root
);

  localparam int RW = (NW + 1) / 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic [2*RW-1:0]  nsh;
  logic [RW:0]      rem;
  logic [RW-1:0]    acc_root;
  logic [RW+2:0]    trial_rem;
  logic [RW+2:0]    trial;
  logic [RW+2:0]    diff;
  logic             fits;
  logic [CNT_W-1:0] steps;

  // Two radicand bits come down per cycle and one root bit is decided.
  assign trial_rem = {rem, nsh[2*RW-1 -: 2]};
  assign trial     = {1'b0, acc_root, 2'b01};
  assign diff      = trial_rem - trial;
  assign fits      = (trial_rem >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= CNT_W'(RW);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh      <= (2*RW)'(n);
      rem      <= '0;
      acc_root <= '0;
    end else if (steps != '0) begin
      nsh      <= {nsh[2*RW-3:0], 2'b00};
      rem      <= fits ? diff[RW:0] : trial_rem[RW:0];
      acc_root <= {acc_root[RW-2:0], fits};
    end
  end

  assign busy = (steps != '0);
  assign root = acc_root;

endmodule

/* tb/sv/nearest_segment_hit_test_tb.sv */
`timescale 1ns / 1ps

module nearest_segment_hit_test_tb;
  import nsht_pkg::*;

  localparam int MAX_SEG = MAX_SEGMENTS_DEFAULT;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_AT = 12000;
  localparam int HOLD_CYCLES = 900;
  localparam int QUIET_FROM = 25000;
  localparam int QUIET_TO = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0;
  logic seg_stall;
  seg_item_t seg = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  hit_result_t res;

  nearest_segment_hit_test dut (
    .clk(clk),
    .rst(rst),
    .seg_valid(seg_valid),
    .seg_stall(seg_stall),
    .seg(seg),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  seg_item_t segs_to_send[$];
  hit_result_t hits_due[$];

  // Running search state of the open run.
  bit run_open = 1'b0;
  int run_pos = 0;
  logic [FIELD_W-1:0] run_min = '0;
  int run_best = 0;
  bit run_hit = 1'b0;
  bit run_ovf = 1'b0;

  int errors = 0;
  int cycle = 0;
  int items_taken = 0;
  int runs_closed = 0;
  int runs_hit = 0;
  int runs_ovf = 0;
  int hold_left = 0;
  int blocked_cycles = 0;
  logic quiet;

  assign quiet = (cycle >= QUIET_FROM) && (cycle < QUIET_TO);

  always @(posedge clk) cycle <= cycle + 1;

  // Largest q in 0..65535 with q*q <= n.
  function automatic logic [15:0] root_floor(input logic [127:0] n);
    logic [15:0] q;
    logic [127:0] t;
    q = '0;
    for (int b = 15; b >= 0; b--) begin
      t = 128'(q | (16'd1 << b));
      if (t * t <= n) q = t[15:0];
    end
    return q;
  endfunction

  // Largest q in 0..65535 with q*q*len <= cross2, i.e. |cross| / sqrt(len) floored.
  function automatic logic [15:0] root_ratio(input logic [127:0] cross2,
                                             input logic [127:0] len);
    logic [15:0] q;
    logic [127:0] t;
    q = '0;
    for (int b = 15; b >= 0; b--) begin
      t = 128'(q | (16'd1 << b));
      if (len * t * t <= cross2) q = t[15:0];
    end
    return q;
  endfunction

  function automatic logic [15:0] point_seg_distance(input seg_item_t it);
    longint qx, qy, ax, ay, bx, by, dx, dy, px, py, len, dot, crs;
    logic [127:0] c2;
    qx = longint'($signed(it.query_x));
    qy = longint'($signed(it.query_y));
    ax = longint'($signed(it.seg_start_x));
    ay = longint'($signed(it.seg_start_y));
    bx = longint'($signed(it.seg_end_x));
    by = longint'($signed(it.seg_end_y));
    dx = bx - ax;
    dy = by - ay;
    px = qx - ax;
    py = qy - ay;
    len = dx * dx + dy * dy;
    if (len == 0) return root_floor(128'(px * px + py * py));
    dot = px * dx + py * dy;
    if (dot <= 0) return root_floor(128'(px * px + py * py));
    if (dot >= len) return root_floor(128'((qx - bx) * (qx - bx) + (qy - by) * (qy - by)));
    crs = px * dy - py * dx;
    if (crs < 0) crs = -crs;
    c2 = 128'(crs) * 128'(crs);
    return root_ratio(c2, 128'(len));
  endfunction

  // Folds one accepted item into the open run; the last item yields a result.
  task automatic fold_segment(input seg_item_t it);
    logic [15:0] d;
    hit_result_t r;
    if (!run_open) begin
      run_open = 1'b1;
      run_pos = 0;
      run_min = it.search_radius;
      run_best = 0;
      run_hit = 1'b0;
      run_ovf = 1'b0;
    end
    if (run_pos >= MAX_SEG) begin
      run_ovf = 1'b1;
    end else begin
      if (it.eligible) begin
        d = point_seg_distance(it);
        if (d < run_min) begin
          run_min = d;
          run_best = run_pos;
          run_hit = 1'b1;
        end
      end
      run_pos++;
    end
    items_taken++;
    if (it.last_segment) begin
      r.found = run_hit;
      r.best_index = run_hit ? run_best[IDX_W-1:0] : '0;
      r.best_distance = run_min;
      r.overflow = run_ovf;
      hits_due.push_back(r);
      run_open = 1'b0;
      runs_closed++;
      if (run_hit) runs_hit++;
      if (run_ovf) runs_ovf++;
    end
  endtask

  // Sender: a new item is offered only once the current one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (!seg_valid || !seg_stall) begin
      if (seg_valid) fold_segment(seg);
      if (segs_to_send.size() > 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
        seg <= segs_to_send.pop_front();
        seg_valid <= 1'b1;
      end else begin
        seg_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
    end else if (cycle == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= (hold_left > 1);
      if (seg_valid && seg_stall) blocked_cycles <= blocked_cycles + 1;
    end else begin
      res_stall <= !quiet && ($urandom_range(0, 99) < 16);
    end
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    hit_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (hits_due.size() == 0) begin
        $display("%0t: result with none expected, got found=%0d index=%0d dist=%0d ovf=%0d",
                 $time, res.found, res.best_index, res.best_distance, res.overflow);
        errors++;
      end else begin
        want = hits_due.pop_front();
        check_field("found", want.found, res.found);
        check_field("best_index", want.best_index, res.best_index);
        check_field("best_distance", want.best_distance, res.best_distance);
        check_field("overflow", want.overflow, res.overflow);
      end
    end
  end

  task automatic put(input int qx, input int qy, input int rad, input int ax, input int ay,
                     input int bx, input int by, input bit elig, input bit last);
    seg_item_t it;
    it.query_x = 16'(qx);
    it.query_y = 16'(qy);
    it.search_radius = 16'(rad);
    it.seg_start_x = 16'(ax);
    it.seg_start_y = 16'(ay);
    it.seg_end_x = 16'(bx);
    it.seg_end_y = 16'(by);
    it.eligible = elig;
    it.last_segment = last;
    segs_to_send.push_back(it);
  endtask

  // Long run of mostly ineligible items at distance zero; the items past the limit are eligible.
  task automatic add_long_run(input int n, input int hit_pos);
    for (int i = 0; i < n; i++) begin
      if (i == hit_pos) put(0, 0, 1000, 5, 0, 5, 0, 1'b1, i == n - 1);
      else put(0, 0, 1000, 0, 0, 0, 0, i >= MAX_SEG, i == n - 1);
    end
  endtask

  function automatic logic [15:0] near_coord(input logic [15:0] c, input int spread);
    if (spread >= 32768) return 16'($urandom);
    return 16'(int'($signed(c)) + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic add_random_run(input int max_len, input int spread);
    seg_item_t it;
    seg_item_t prev;
    int n;
    logic [15:0] qx, qy, rad;
    n = $urandom_range(1, max_len);
    qx = 16'($urandom);
    qy = 16'($urandom);
    case ($urandom_range(0, 3))
      0: rad = 16'($urandom);
      1: rad = DIST_SAT;
      default: rad = 16'($urandom_range(0, 2 * spread));
    endcase
    prev = '0;
    for (int i = 0; i < n; i++) begin
      it.query_x = ($urandom_range(0, 9) == 0) ? 16'($urandom) : qx;
      it.query_y = ($urandom_range(0, 9) == 0) ? 16'($urandom) : qy;
      // Only the first item's radius counts; later ones are noise.
      it.search_radius = (i == 0) ? rad : 16'($urandom);
      it.seg_start_x = near_coord(qx, spread);
      it.seg_start_y = near_coord(qy, spread);
      it.seg_end_x = near_coord(qx, spread);
      it.seg_end_y = near_coord(qy, spread);
      case ($urandom_range(0, 9))
        0: begin
          it.seg_end_x = it.seg_start_x;
          it.seg_end_y = it.seg_start_y;
        end
        1: if (i > 0) begin
          it.seg_start_x = prev.seg_start_x;
          it.seg_start_y = prev.seg_start_y;
          it.seg_end_x = prev.seg_end_x;
          it.seg_end_y = prev.seg_end_y;
          it.query_x = prev.query_x;
          it.query_y = prev.query_y;
        end
        default: ;
      endcase
      it.eligible = ($urandom_range(0, 99) < 85);
      it.last_segment = (i == n - 1);
      segs_to_send.push_back(it);
      prev = it;
    end
  endtask

  initial begin : stimulus
    int base;
    int pick;
    int spreads[3];
    spreads = '{16, 256, 4096};

    // Zero-length segment.
    put(0, 0, 65535, 48, 64, 48, 64, 1'b1, 1'b1);
    // Projection before the start, and a dot product of exactly zero.
    put(0, 0, 65535, 16, 0, 64, 0, 1'b1, 1'b1);
    put(0, 32, 65535, 0, 0, 64, 0, 1'b1, 1'b1);
    // Projection past the end, and a dot product equal to the squared length.
    put(100, 0, 65535, 0, 0, 64, 0, 1'b1, 1'b1);
    put(64, 10, 65535, 0, 0, 64, 0, 1'b1, 1'b1);
    // Interior projections, one off axis.
    put(32, 50, 65535, 0, 0, 64, 0, 1'b1, 1'b1);
    put(7, -3, 65535, -100, 50, 100, -60, 1'b1, 1'b1);
    // Coordinate extremes; the distance reaches or saturates at 65535 and nothing is found.
    put(-32768, -32768, 65535, 32767, 32767, 32767, 32767, 1'b1, 1'b1);
    put(32767, -32768, 65535, -32768, 32767, 32767, 32767, 1'b1, 1'b1);
    put(-32768, 32767, 65535, -32768, -32768, 32767, -32768, 1'b1, 1'b1);
    // Zero radius finds nothing, even at distance zero.
    put(5, 5, 0, 5, 5, 5, 5, 1'b1, 1'b1);
    // Distance equal to the radius misses; one more hits.
    put(0, 0, 50, 0, 50, 0, 50, 1'b1, 1'b1);
    put(0, 0, 51, 0, 50, 0, 50, 1'b1, 1'b1);
    // Tie keeps the earlier segment.
    put(0, 0, 1000, 10, 0, 10, 100, 1'b1, 1'b0);
    put(0, 0, 1000, 10, 0, 10, 100, 1'b1, 1'b1);
    // An ineligible segment at distance zero is passed over.
    put(0, 0, 1000, 0, 0, 0, 0, 1'b0, 1'b0);
    put(0, 0, 1000, 40, 0, 40, 0, 1'b1, 1'b0);
    put(0, 0, 1000, 20, 0, 20, 0, 1'b1, 1'b1);
    // Radius latched from the first item only.
    put(0, 0, 30, 40, 0, 40, 0, 1'b1, 1'b0);
    put(0, 0, 65535, 35, 0, 35, 0, 1'b1, 1'b1);
    // Run with no eligible segment.
    put(0, 0, 777, 1, 1, 2, 2, 1'b0, 1'b1);

    // Runs at, just over and well over the segment limit.
    add_long_run(MAX_SEG, MAX_SEG - 1);
    add_long_run(MAX_SEG + 1, 100);
    add_long_run(MAX_SEG + 4, MAX_SEG - 1);

    base = segs_to_send.size();
    while (segs_to_send.size() - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) add_random_run(6, spreads[$urandom_range(0, 2)]);
      else if (pick < 80) add_random_run(40, spreads[$urandom_range(0, 2)]);
      else add_random_run(4, 32768);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (segs_to_send.size() != 0 || seg_valid) @(posedge clk);
    while (hits_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d items in %0d runs, %0d with a hit, %0d overlong; %0d mismatches.",
             items_taken, runs_closed, runs_hit, runs_ovf, errors);
    $display("Input held back for %0d cycles while results were blocked.", blocked_cycles);
    if (errors == 0) begin
      $display("nearest_segment_hit_test_tb: clean");
    end else begin
      $display("nearest_segment_hit_test_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("%0t: run timed out with %0d results outstanding", $time, hits_due.size());
    $display("nearest_segment_hit_test_tb: errors");
    $finish;
  end

endmodule
